// ===== src/fqsa_pkg.sv =====
`timescale 1ns / 1ps

package fqsa_pkg;

  // Queue geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int SUM_W  = DATA_W + $clog2(DEPTH);

  // Mean divider: quotient bits retired per cycle and resulting cycle count
  localparam int DIV_BITS = 4;
  localparam int DIV_ITER = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W    = DIV_ITER * DIV_BITS;
  localparam int ITER_W   = $clog2(DIV_ITER);

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2,
    OP_QRY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RD    = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_e;

  // Ring pointer advance with wrap at DEPTH
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== src/fqsa_ram.sv =====
`timescale 1ns / 1ps

module fqsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fqsa_div.sv =====
`timescale 1ns / 1ps

module fqsa_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fqsa_pkg::SUM_W-1:0] dividend_i,
  input  logic [fqsa_pkg::CNT_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic signed [fqsa_pkg::DATA_W-1:0] quotient_o
);

  import fqsa_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q;
  logic              neg_q;
  logic              zero_q;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [DATA_W-1:0] q_mag;

  // magnitude of the dividend; the most negative sum still fits unsigned
  assign mag = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : dividend_i;

  // restoring steps, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = CNT_W'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(DIV_ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= DIV_W'(mag);
      rem_q  <= '0;
      den_q  <= divisor_i;
      neg_q  <= dividend_i[SUM_W-1];
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign q_mag      = quo_q[DATA_W-1:0];
  assign quotient_o = zero_q ? '0 : (neg_q ? -q_mag : q_mag);
  assign done_o     = done_q;

endmodule

// ===== src/fifo_queue_with_sum_average.sv =====
`timescale 1ns / 1ps

// FIFO queue of signed 32-bit values (16 entries) with running sum and mean.
// Each input transfer carries one operation: enqueue, dequeue, clear or query.
// Every operation yields exactly one result transfer reporting the dequeued
// value (zero unless a dequeue succeeded), a status (done, full, empty), the
// occupancy, the running sum of held entries, the mean truncated toward zero
// (zero when empty) and the empty/full flags. An enqueue to a full queue is
// dropped with status full; a dequeue from an empty queue is refused with
// status empty. Entries live in a single-port-write, registered-read RAM; the
// sum and count are registers updated as entries come and go, so no walk of
// the store is ever needed. Timing: one operation at a time. An operation
// runs from input transfer through ST_START and ST_DIV to the load of the
// output register, via ST_HOLD while that register cannot take it; a
// successful dequeue first passes ST_RD for the RAM read. In ST_DIV the mean
// divider retires 4 quotient bits per cycle over the 36-bit sum. Input stall
// is high from the accepting edge until the result is handed to the output
// register; a result waiting on output stall does not block the next
// operation from starting, only the one after it from finishing.
module fifo_queue_with_sum_average (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic signed [fqsa_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fqsa_pkg::DATA_W-1:0]  dequeued_o,
  output logic [1:0]                          status_o,
  output logic [fqsa_pkg::CNT_W-1:0]          occupancy_o,
  output logic signed [fqsa_pkg::SUM_W-1:0]   total_o,
  output logic signed [fqsa_pkg::DATA_W-1:0]  mean_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  import fqsa_pkg::*;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         front_q, front_d;
  logic [IDX_W-1:0]         rear_q, rear_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  status_e                  sts_q, sts_d;
  logic [DATA_W-1:0]        deq_q, deq_d;

  // output register
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_deq_q;
  status_e                  out_sts_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic signed [DATA_W-1:0] out_mean_q;

  op_e                      op;
  logic                     in_xfer;
  logic                     out_xfer;
  logic                     out_free;
  logic                     out_load;
  logic                     full;
  logic                     empty;
  logic                     ram_we;
  logic                     ram_re;
  logic [DATA_W-1:0]        ram_rdata;
  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  // Enqueue writes at the tail on the accepting edge; a dequeue reads the
  // head on the same edge and consumes the data in ST_RD. Only one operation
  // is in flight, so a write and a read of the same entry never overlap.
  assign ram_we = in_xfer && (op == OP_ENQ) && !full;
  assign ram_re = in_xfer && (op == OP_DEQ) && !empty;

  fqsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rear_q),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (front_q),
    .rdata_o (ram_rdata)
  );

  // mean = sum / count, started once the queue state has settled
  assign div_start = (state_q == ST_START);

  fqsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_load = ((state_q == ST_DIV && div_done) || state_q == ST_HOLD) && out_free;

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    rear_d  = rear_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    sts_d   = sts_q;
    deq_d   = deq_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sts_d   = STS_DONE;
          deq_d   = '0;
          state_d = ST_START;
          case (op)
            OP_ENQ: begin
              if (full) begin
                sts_d = STS_FULL;
              end else begin
                rear_d = next_idx(rear_q);
                cnt_d  = cnt_q + 1'b1;
                sum_d  = sum_q + SUM_W'(value_i);
              end
            end
            OP_DEQ: begin
              if (empty) begin
                sts_d = STS_EMPTY;
              end else begin
                state_d = ST_RD;
              end
            end
            OP_CLR: begin
              front_d = '0;
              rear_d  = '0;
              cnt_d   = '0;
              sum_d   = '0;
            end
            default: begin
              // query: state untouched
            end
          endcase
        end
      end
      ST_RD: begin
        deq_d   = ram_rdata;
        sum_d   = sum_q - SUM_W'($signed(ram_rdata));
        front_d = next_idx(front_q);
        cnt_d   = cnt_q - 1'b1;
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      sts_q       <= STS_DONE;
      deq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      sts_q   <= sts_d;
      deq_q   <= deq_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_deq_q  <= deq_q;
      out_sts_q  <= sts_q;
      out_cnt_q  <= cnt_q;
      out_sum_q  <= sum_q;
      out_mean_q <= div_quo;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dequeued_o  = out_deq_q;
  assign status_o    = out_sts_q;
  assign occupancy_o = out_cnt_q;
  assign total_o     = out_sum_q;
  assign mean_o      = out_mean_q;
  assign is_empty_o  = (out_cnt_q == '0);
  assign is_full_o   = (out_cnt_q == CNT_W'(DEPTH));

`ifndef SYNTH
  // occupancy never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // an empty queue holds a zero sum
  a_sum_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with empty queue");

  // tail pointer stays front plus count, modulo depth
  a_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, front_q} + cnt_q) % (CNT_W + 1)'(DEPTH)) == (CNT_W + 1)'(rear_q))
    else $error("ring pointers out of step");

  // a dequeue of a held entry goes through the RAM read cycle
  a_deq_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op == OP_DEQ && !empty) |=> (state_q == ST_RD))
    else $error("dequeue skipped RAM read");

  // divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside wait state");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fqsa_pkg::*;

  localparam int RAND_ITEMS = 1800;
  localparam int LONG_HOLD  = 300;  // cycles the output side refuses results once

  // One result transfer, fields kept unsigned so compares are plain bit compares
  typedef struct packed {
    logic [DATA_W-1:0] deq;
    status_e           st;
    logic [CNT_W-1:0]  occ;
    logic [SUM_W-1:0]  tot;
    logic [DATA_W-1:0] mean;
    logic              emp;
    logic              full;
  } queue_result_t;

  // Directed row: op repeated reps times; want is used only when known is set
  typedef struct packed {
    op_e           op;
    logic [31:0]   val;
    int            reps;
    logic          known;
    queue_result_t want;
  } plan_row_t;

  localparam int N_PLAN = 17;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] operation_i = 2'd0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [DATA_W-1:0] dequeued_o;
  logic [1:0] status_o;
  logic [CNT_W-1:0] occupancy_o;
  logic signed [SUM_W-1:0] total_o;
  logic signed [DATA_W-1:0] mean_o;
  logic is_empty_o;
  logic is_full_o;

  // Shadow queue state used to predict every result
  logic [DATA_W-1:0] ring [DEPTH];
  int     front = 0;
  int     held = 0;
  longint run_sum = 0;

  queue_result_t pending_results[$];
  plan_row_t     plan [N_PLAN];

  int  mismatch_cnt = 0;
  int  results_seen = 0;
  int  ops_sent = 0;
  int  n_full_rej = 0;
  int  n_empty_rej = 0;
  int  n_clears = 0;
  int  peak_held = 0;
  bit  sender_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  hold_done = 1'b0;

  fifo_queue_with_sum_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dequeued_o  (dequeued_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .total_o     (total_o),
    .mean_o      (mean_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name,
                                got, want));
    end
  endtask

  // Applies one operation to the shadow queue and returns its result
  function automatic queue_result_t predict_queue_result(op_e op, logic [31:0] val);
    queue_result_t r;
    longint avg;
    r = '0;
    r.st = STS_DONE;
    avg = 0;
    case (op)
      OP_ENQ: begin
        if (held == DEPTH) begin
          r.st = STS_FULL;
          n_full_rej++;
        end else begin
          ring[(front + held) % DEPTH] = val;
          held++;
          run_sum += longint'(signed'(val));
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          r.st = STS_EMPTY;
          n_empty_rej++;
        end else begin
          r.deq = ring[front];
          front = (front + 1) % DEPTH;
          held--;
          run_sum -= longint'(signed'(r.deq));
        end
      end
      OP_CLR: begin
        front = 0;
        held = 0;
        run_sum = 0;
        n_clears++;
      end
      default: ;  // query leaves the queue alone
    endcase
    if (held != 0) begin
      avg = run_sum / held;  // truncates toward zero
    end
    if (held > peak_held) begin
      peak_held = held;
    end
    r.occ = CNT_W'(held);
    r.tot = run_sum[SUM_W-1:0];
    r.mean = avg[DATA_W-1:0];
    r.emp = (held == 0);
    r.full = (held == DEPTH);
    return r;
  endfunction

  // Offers one operation, waits for the transfer, then records what it should yield.
  // A zero gap keeps valid high straight into the next item.
  task automatic offer_op(op_e op, logic [31:0] val, logic known, queue_result_t want);
    int gap;
    int r;
    queue_result_t pred;
    gap = 0;
    r = $urandom_range(99);
    if (!sender_calm) begin
      if (r >= 92) begin
        gap = $urandom_range(50, 15);
      end else if (r >= 65) begin
        gap = $urandom_range(3, 1);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i <= op;
    value_i <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    ops_sent++;
    pred = predict_queue_result(op, val);
    pending_results.push_back(known ? want : pred);
  endtask

  task automatic check_result();
    queue_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result transfer with nothing pending");
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    check_field("dequeued", 64'($unsigned(dequeued_o)), 64'(want.deq));
    check_field("status", 64'(status_o), 64'(want.st));
    check_field("occupancy", 64'(occupancy_o), 64'(want.occ));
    check_field("total", 64'($unsigned(total_o)), 64'(want.tot));
    check_field("mean", 64'($unsigned(mean_o)), 64'(want.mean));
    check_field("is_empty", 64'(is_empty_o), 64'(want.emp));
    check_field("is_full", 64'(is_full_o), 64'(want.full));
  endtask

  // Output side: checks each transfer and stalls at random. Once, early on, it
  // refuses results for a long stretch so the queue backs up into the input.
  initial begin : result_side
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_result();
        if (results_seen % 100 == 0) begin
          recv_calm = ($urandom_range(3) == 0);
        end
      end
      if (!hold_done && results_seen >= 120) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (recv_calm || r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(39, 9);
        end
      end
    end
  end

  initial begin : stimulus
    int enq_pct;
    int r;
    op_e op;
    logic [31:0] val;

    // Rows with known set carry results that follow directly from the queue
    // contents: reset state, refusals, clears and the sum extremes.
    plan = '{
      '{OP_QRY, 32'h0000_0000, 1, 1'b1,
        '{32'd0, STS_DONE, 5'd0, 36'd0, 32'd0, 1'b1, 1'b0}},
      '{OP_DEQ, 32'hDEAD_BEEF, 1, 1'b1,
        '{32'd0, STS_EMPTY, 5'd0, 36'd0, 32'd0, 1'b1, 1'b0}},
      '{OP_ENQ, 32'h7FFF_FFFF, 16, 1'b0, '0},
      '{OP_ENQ, 32'h0000_0001, 1, 1'b1,
        '{32'd0, STS_FULL, 5'd16, 36'h7_FFFF_FFF0, 32'h7FFF_FFFF, 1'b0, 1'b1}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b0, '0},
      '{OP_CLR, 32'hFFFF_FFFF, 1, 1'b1,
        '{32'd0, STS_DONE, 5'd0, 36'd0, 32'd0, 1'b1, 1'b0}},
      '{OP_ENQ, 32'h8000_0000, 16, 1'b0, '0},
      '{OP_ENQ, 32'h1234_5678, 1, 1'b1,
        '{32'd0, STS_FULL, 5'd16, 36'h8_0000_0000, 32'h8000_0000, 1'b0, 1'b1}},
      '{OP_DEQ, 32'h0000_0000, 1, 1'b0, '0},
      '{OP_ENQ, 32'h0000_0005, 1, 1'b0, '0},   // lands in slot 0: ring wrap
      '{OP_CLR, 32'h0000_0000, 1, 1'b1,
        '{32'd0, STS_DONE, 5'd0, 36'd0, 32'd0, 1'b1, 1'b0}},
      '{OP_ENQ, 32'h0000_0005, 1, 1'b0, '0},
      '{OP_ENQ, 32'hFFFF_FFF8, 1, 1'b0, '0},   // mean -3/2 truncates to -1
      '{OP_DEQ, 32'h0000_0000, 1, 1'b0, '0},
      '{OP_QRY, 32'hAAAA_AAAA, 1, 1'b0, '0},
      '{OP_ENQ, 32'h5555_5555, 1, 1'b0, '0},
      '{OP_CLR, 32'h0000_0000, 1, 1'b1,
        '{32'd0, STS_DONE, 5'd0, 36'd0, 32'd0, 1'b1, 1'b0}}
    };
    enq_pct = 55;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        offer_op(plan[i].op, plan[i].val, plan[i].known, plan[i].want);
      end
    end

    // Random part in phases: filling, draining or balanced, so occupancy sweeps
    // the whole range and both refusals come up regularly.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 25;
          default: enq_pct = 55;
        endcase
        sender_calm = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (r < 2) begin
        op = OP_CLR;
      end else if (r < 10) begin
        op = OP_QRY;
      end else if ($urandom_range(99) < enq_pct) begin
        op = OP_ENQ;
      end else begin
        op = OP_DEQ;
      end
      case ($urandom_range(9))
        0: val = 32'h7FFF_FFFF;
        1: val = 32'h8000_0000;
        2: val = 32'($signed($urandom_range(20)) - 10);
        default: val = $urandom;
      endcase
      offer_op(op, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);  // catch any stray result after the last one

    $display("Sent %0d operations, checked %0d results: %0d full drops, %0d empty refusals,",
             ops_sent, results_seen, n_full_rej, n_empty_rej);
    $display("%0d clears, peak occupancy %0d of %0d, one %0d-cycle output hold-off.",
             n_clears, peak_held, DEPTH, LONG_HOLD);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fqsa_pkg.sv
src/fqsa_ram.sv
src/fqsa_div.sv
src/fifo_queue_with_sum_average.sv
test/testbench.sv
